@@ rtl/core/skf_pkg.sv @@
// Shared types, constants and microcode for the scalar Kalman speed fusion block.
// Holds the control word layout, the step program and the saturation helper.
// Depends on nothing; imported by scalar_kalman_speed_fusion and its testbench.
package skf_pkg;

  // Field and register widths.
  localparam int unsigned VAL_W   = 32;  // signed Q16.16 values
  localparam int unsigned UNC_W   = 31;  // unsigned Q15.16 uncertainty
  localparam int unsigned CFG_W   = 21;  // widest register
  localparam int unsigned CIDX_W  = 3;
  localparam int unsigned PC_W    = 5;
  localparam int unsigned TMP_W   = 36;  // scratch register, holds rounded products
  localparam int unsigned MULA_W  = 34;
  localparam int unsigned MULB_W  = 18;
  localparam int unsigned PROD_W  = MULA_W + MULB_W;
  localparam int unsigned DEN_W   = 34;
  localparam int unsigned GAIN_W  = 17;
  localparam int unsigned CNT_W   = 5;

  // Register indexes of the configuration port.
  localparam logic [CIDX_W-1:0] CFG_STEP_TIME     = 3'd0;
  localparam logic [CIDX_W-1:0] CFG_PROCESS_NOISE = 3'd1;
  localparam logic [CIDX_W-1:0] CFG_NOISE_FLOOR   = 3'd2;
  localparam logic [CIDX_W-1:0] CFG_NOISE_SLOPE   = 3'd3;
  localparam logic [CIDX_W-1:0] CFG_BIAS_GAIN     = 3'd4;
  localparam logic [CIDX_W-1:0] CFG_WARMUP_ITEMS  = 3'd5;

  // Register reset values.
  localparam logic [16:0] RST_STEP_TIME     = 17'd6554;
  localparam logic [20:0] RST_PROCESS_NOISE = 21'd32768;
  localparam logic [20:0] RST_NOISE_FLOOR   = 21'd19661;
  localparam logic [16:0] RST_NOISE_SLOPE   = 17'd6554;
  localparam logic [16:0] RST_BIAS_GAIN     = 17'd32768;
  localparam logic [5:0]  RST_WARMUP_ITEMS  = 6'd50;

  localparam logic [GAIN_W-1:0] GAIN_ONE   = 17'h10000;
  localparam logic [CNT_W-1:0]  DIV_STEPS  = 5'd16;  // quotient bits minus one

  // Saturation limits on a 37-bit intermediate sum.
  localparam logic signed [36:0] S32_MAX_X = 37'sd2147483647;
  localparam logic signed [36:0] S32_MIN_X = -37'sd2147483648;

  // Datapath operations, one per control word.
  typedef enum logic [4:0] {
    OP_NOP,
    OP_SEED,       // seed bias on first item, latch correction decision
    OP_SUM,        // tmp = sat(accel + bias)
    OP_MUL,        // prod = A * B
    OP_RND,        // tmp = prod >> 16, rounded half away from zero
    OP_ADD_SPEED,  // speed = sat(speed + tmp)
    OP_UNC_PN,     // uncertainty += process noise, saturated
    OP_ABS,        // tmp = |speed|
    OP_RSEL,       // den = uncertainty + max(floor, tmp)
    OP_DIVINIT,    // load divider with rounded dividend
    OP_DIVSTEP,    // one restoring division bit
    OP_KSET,       // gain = quotient, zero when den is zero
    OP_DIFF,       // tmp = gps - speed
    OP_KB,         // bias gain product = tmp
    OP_ADD_BIAS,   // bias = sat(bias + tmp)
    OP_UNC_SET,    // uncertainty = tmp, saturated
    OP_WARM,       // advance warm-up count
    OP_OUT         // load the output register
  } op_e;

  typedef enum logic [1:0] {
    A_T,
    A_K,
    A_UNC
  } asel_e;

  typedef enum logic [2:0] {
    B_DT,
    B_SLOPE,
    B_K,
    B_BG,
    B_KB,
    B_ONE_MINUS_K
  } bsel_e;

  // Sequencing of the step counter.
  typedef enum logic [2:0] {
    JC_NEXT,       // next step
    JC_GOTO,       // unconditional jump
    JC_WAIT_IN,    // hold until a request is taken
    JC_IF_NOCORR,  // jump when no correction applies
    JC_DIV_LOOP,   // repeat while division bits remain
    JC_WAIT_OUT    // hold while the output slot is full, then jump
  } jc_e;

  typedef struct packed {
    op_e             op;
    asel_e           a_sel;
    bsel_e           b_sel;
    jc_e             jc;
    logic [PC_W-1:0] target;
  } ctrl_word_t;

  // Named program addresses.
  localparam logic [PC_W-1:0] ST_IDLE = 5'd0;
  localparam logic [PC_W-1:0] ST_DIV  = 5'd12;
  localparam logic [PC_W-1:0] ST_WARM = 5'd28;
  localparam logic [PC_W-1:0] ST_OUT  = 5'd29;

  // Microcode program. A step that holds repeats until it may advance.
  function automatic ctrl_word_t ucode(input logic [PC_W-1:0] pc);
    ctrl_word_t w;
    w = '{op: OP_NOP, a_sel: A_T, b_sel: B_DT, jc: JC_GOTO, target: ST_IDLE};
    case (pc)
      ST_IDLE: w = '{op: OP_NOP,     a_sel: A_T,   b_sel: B_DT,   jc: JC_WAIT_IN,
                   target: ST_IDLE};
      5'd1:  w = '{op: OP_SEED,      a_sel: A_T,   b_sel: B_DT,   jc: JC_NEXT,
                   target: ST_IDLE};
      5'd2:  w = '{op: OP_SUM,       a_sel: A_T,   b_sel: B_DT,   jc: JC_NEXT,
                   target: ST_IDLE};
      5'd3:  w = '{op: OP_MUL,       a_sel: A_T,   b_sel: B_DT,   jc: JC_NEXT,
                   target: ST_IDLE};
      5'd4:  w = '{op: OP_RND,       a_sel: A_T,   b_sel: B_DT,   jc: JC_NEXT,
                   target: ST_IDLE};
      5'd5:  w = '{op: OP_ADD_SPEED, a_sel: A_T,   b_sel: B_DT,   jc: JC_NEXT,
                   target: ST_IDLE};
      5'd6:  w = '{op: OP_UNC_PN,    a_sel: A_T,   b_sel: B_DT,   jc: JC_IF_NOCORR,
                   target: ST_WARM};
      5'd7:  w = '{op: OP_ABS,       a_sel: A_T,   b_sel: B_DT,   jc: JC_NEXT,
                   target: ST_IDLE};
      5'd8:  w = '{op: OP_MUL,       a_sel: A_T,   b_sel: B_SLOPE, jc: JC_NEXT,
                   target: ST_IDLE};
      5'd9:  w = '{op: OP_RND,       a_sel: A_T,   b_sel: B_DT,   jc: JC_NEXT,
                   target: ST_IDLE};
      5'd10: w = '{op: OP_RSEL,      a_sel: A_T,   b_sel: B_DT,   jc: JC_NEXT,
                   target: ST_IDLE};
      5'd11: w = '{op: OP_DIVINIT,   a_sel: A_T,   b_sel: B_DT,   jc: JC_NEXT,
                   target: ST_IDLE};
      ST_DIV: w = '{op: OP_DIVSTEP,  a_sel: A_T,   b_sel: B_DT,   jc: JC_DIV_LOOP,
                   target: ST_DIV};
      5'd13: w = '{op: OP_KSET,      a_sel: A_T,   b_sel: B_DT,   jc: JC_NEXT,
                   target: ST_IDLE};
      5'd14: w = '{op: OP_DIFF,      a_sel: A_T,   b_sel: B_DT,   jc: JC_NEXT,
                   target: ST_IDLE};
      5'd15: w = '{op: OP_MUL,       a_sel: A_T,   b_sel: B_K,    jc: JC_NEXT,
                   target: ST_IDLE};
      5'd16: w = '{op: OP_RND,       a_sel: A_T,   b_sel: B_DT,   jc: JC_NEXT,
                   target: ST_IDLE};
      5'd17: w = '{op: OP_ADD_SPEED, a_sel: A_T,   b_sel: B_DT,   jc: JC_NEXT,
                   target: ST_IDLE};
      5'd18: w = '{op: OP_MUL,       a_sel: A_K,   b_sel: B_BG,   jc: JC_NEXT,
                   target: ST_IDLE};
      5'd19: w = '{op: OP_RND,       a_sel: A_T,   b_sel: B_DT,   jc: JC_NEXT,
                   target: ST_IDLE};
      5'd20: w = '{op: OP_KB,        a_sel: A_T,   b_sel: B_DT,   jc: JC_NEXT,
                   target: ST_IDLE};
      5'd21: w = '{op: OP_DIFF,      a_sel: A_T,   b_sel: B_DT,   jc: JC_NEXT,
                   target: ST_IDLE};
      5'd22: w = '{op: OP_MUL,       a_sel: A_T,   b_sel: B_KB,   jc: JC_NEXT,
                   target: ST_IDLE};
      5'd23: w = '{op: OP_RND,       a_sel: A_T,   b_sel: B_DT,   jc: JC_NEXT,
                   target: ST_IDLE};
      5'd24: w = '{op: OP_ADD_BIAS,  a_sel: A_T,   b_sel: B_DT,   jc: JC_NEXT,
                   target: ST_IDLE};
      5'd25: w = '{op: OP_MUL,       a_sel: A_UNC, b_sel: B_ONE_MINUS_K, jc: JC_NEXT,
                   target: ST_IDLE};
      5'd26: w = '{op: OP_RND,       a_sel: A_T,   b_sel: B_DT,   jc: JC_NEXT,
                   target: ST_IDLE};
      5'd27: w = '{op: OP_UNC_SET,   a_sel: A_T,   b_sel: B_DT,   jc: JC_NEXT,
                   target: ST_IDLE};
      ST_WARM: w = '{op: OP_WARM,    a_sel: A_T,   b_sel: B_DT,   jc: JC_NEXT,
                   target: ST_IDLE};
      ST_OUT: w = '{op: OP_OUT,      a_sel: A_T,   b_sel: B_DT,   jc: JC_WAIT_OUT,
                   target: ST_IDLE};
      default: w = '{op: OP_NOP, a_sel: A_T, b_sel: B_DT, jc: JC_GOTO, target: ST_IDLE};
    endcase
    return w;
  endfunction

  // Clamp a 37-bit signed sum to the signed 32-bit range.
  function automatic logic signed [VAL_W-1:0] sat32(input logic signed [36:0] v);
    logic signed [VAL_W-1:0] r;
    if (v > S32_MAX_X) begin
      r = 32'sh7FFF_FFFF;
    end else if (v < S32_MIN_X) begin
      r = 32'sh8000_0000;
    end else begin
      r = signed'(v[31:0]);
    end
    return r;
  endfunction

endpackage

@@ rtl/core/scalar_kalman_speed_fusion.sv @@
// Scalar Kalman speed fusion with accelerometer bias tracking, top level.
// A microcoded sequencer steps one shared multiplier and a bit-serial divider.
// Depends on skf_pkg for the control word, the program and the saturation helper.
//
//   channel    direction  payload (lowest bit first)
//   s_axis     in         tdata: ground_speed[31:0], forward_accel[63:32]
//   m_axis     out        tdata: fused_speed, accel_bias, uncertainty_out, pad
//                         tuser: corrected
//   cfg        in         write enable, register index, 21-bit data
//
// An item runs every step of the program when the GPS correction applies and
// jumps from the prediction to the warm-up step when it does not; the next
// request can be taken in the cycle after the result is loaded. The restoring
// division of the gain and the single shared multiplier set the program length.
// Reset returns speed, bias and uncertainty to zero, the warm-up count to one
// and cfg registers to their defaults. A result waiting on the master side
// holds the program at its last step; a new request is taken only at step zero.
module scalar_kalman_speed_fusion (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // Input stream
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  input  logic [63:0]                 s_axis_tdata,   // ground_speed, forward_accel
  // Output stream
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  output logic [95:0]                 m_axis_tdata,   // fused_speed, accel_bias,
                                                      // uncertainty_out, zero pad
  output logic                        m_axis_tuser,   // corrected
  // Configuration writes
  input  logic                        cfg_we_i,
  input  logic [skf_pkg::CIDX_W-1:0]  cfg_idx_i,
  input  logic [skf_pkg::CFG_W-1:0]   cfg_wdata_i
);

  import skf_pkg::*;

  // Configuration registers.
  logic [16:0] step_time_q, step_time_d;
  logic [20:0] process_noise_q, process_noise_d;
  logic [20:0] noise_floor_q, noise_floor_d;
  logic [16:0] noise_slope_q, noise_slope_d;
  logic [16:0] bias_gain_q, bias_gain_d;
  logic [5:0]  warmup_items_q, warmup_items_d;

  // Filter state.
  logic signed [VAL_W-1:0] speed_q, speed_d;
  logic signed [VAL_W-1:0] bias_q, bias_d;
  logic [UNC_W-1:0]        unc_q, unc_d;
  logic [5:0]              wcnt_q, wcnt_d;
  logic                    seeded_q, seeded_d;
  logic                    corr_q, corr_d;

  // Sequencer.
  logic [PC_W-1:0] pc_q, pc_d;
  ctrl_word_t      uword;

  // Working registers.
  logic signed [VAL_W-1:0]  gps_q, gps_d;
  logic signed [VAL_W-1:0]  accel_q, accel_d;
  logic signed [TMP_W-1:0]  t_q, t_d;
  logic signed [PROD_W-1:0] prod_q, prod_d;
  logic [DEN_W-1:0]         den_q, den_d;
  logic [DEN_W-1:0]         rem_q, rem_d;
  logic [16:0]              nlow_q, nlow_d;
  logic [GAIN_W-1:0]        quot_q, quot_d;
  logic [CNT_W-1:0]         cnt_q, cnt_d;
  logic [GAIN_W-1:0]        k_q, k_d;
  logic [GAIN_W-1:0]        kb_q, kb_d;

  // Output register.
  logic                    ovalid_q, ovalid_d;
  logic signed [VAL_W-1:0] ospeed_q, ospeed_d;
  logic signed [VAL_W-1:0] obias_q, obias_d;
  logic [UNC_W-1:0]        ounc_q, ounc_d;
  logic                    ocorr_q, ocorr_d;

  // Datapath intermediates.
  logic                     in_acc;
  logic                     out_stall;
  logic signed [MULA_W-1:0] mul_a;
  logic signed [MULB_W-1:0] mul_b;
  logic signed [PROD_W-1:0] rnd_sum;
  logic signed [36:0]       add37;
  logic [DEN_W-1:0]         r_sel;
  logic [47:0]              dividend;
  logic [DEN_W:0]           trial;
  logic                     trial_ge;
  logic [31:0]              unc_pn;

  assign uword         = ucode(pc_q);
  assign s_axis_tready = (uword.jc == JC_WAIT_IN);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign out_stall     = ovalid_q && !m_axis_tready;

  assign m_axis_tvalid = ovalid_q;
  assign m_axis_tdata  = {1'b0, ounc_q, obias_q, ospeed_q};
  assign m_axis_tuser  = ocorr_q;

  // Configuration register writes.
  always_comb begin
    step_time_d     = step_time_q;
    process_noise_d = process_noise_q;
    noise_floor_d   = noise_floor_q;
    noise_slope_d   = noise_slope_q;
    bias_gain_d     = bias_gain_q;
    warmup_items_d  = warmup_items_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_STEP_TIME:     step_time_d     = cfg_wdata_i[16:0];
        CFG_PROCESS_NOISE: process_noise_d = cfg_wdata_i[20:0];
        CFG_NOISE_FLOOR:   noise_floor_d   = cfg_wdata_i[20:0];
        CFG_NOISE_SLOPE:   noise_slope_d   = cfg_wdata_i[16:0];
        CFG_BIAS_GAIN:     bias_gain_d     = cfg_wdata_i[16:0];
        CFG_WARMUP_ITEMS:  warmup_items_d  = cfg_wdata_i[5:0];
        default: ;
      endcase
    end
  end

  // Next step of the program.
  always_comb begin
    case (uword.jc)
      JC_NEXT:      pc_d = pc_q + 1'b1;
      JC_GOTO:      pc_d = uword.target;
      JC_WAIT_IN:   pc_d = in_acc ? pc_q + 1'b1 : pc_q;
      JC_IF_NOCORR: pc_d = corr_q ? pc_q + 1'b1 : uword.target;
      JC_DIV_LOOP:  pc_d = (cnt_q != '0) ? pc_q : pc_q + 1'b1;
      JC_WAIT_OUT:  pc_d = out_stall ? pc_q : uword.target;
      default:      pc_d = ST_IDLE;
    endcase
  end

  // Shared multiplier operand selection.
  always_comb begin
    case (uword.a_sel)
      A_T:     mul_a = signed'(t_q[MULA_W-1:0]);
      A_K:     mul_a = signed'({17'b0, k_q});
      A_UNC:   mul_a = signed'({3'b0, unc_q});
      default: mul_a = '0;
    endcase
    case (uword.b_sel)
      B_DT:          mul_b = signed'({1'b0, step_time_q});
      B_SLOPE:       mul_b = signed'({1'b0, noise_slope_q});
      B_K:           mul_b = signed'({1'b0, k_q});
      B_BG:          mul_b = signed'({1'b0, bias_gain_q});
      B_KB:          mul_b = signed'({1'b0, kb_q});
      B_ONE_MINUS_K: mul_b = signed'({1'b0, GAIN_ONE - k_q});
      default:       mul_b = '0;
    endcase
  end

  // Shared arithmetic terms.
  always_comb begin
    // Round half away from zero: a negative product rounds with one less.
    rnd_sum  = prod_q + (prod_q[PROD_W-1] ? 52'sd32767 : 52'sd32768);
    r_sel    = (t_q[DEN_W-1:0] > DEN_W'(noise_floor_q)) ? t_q[DEN_W-1:0]
                                                        : DEN_W'(noise_floor_q);
    dividend = {1'b0, unc_q, 16'b0} + 48'(den_q >> 1);
    trial    = {rem_q, nlow_q[16]};
    trial_ge = (trial >= {1'b0, den_q});
    unc_pn   = 32'(unc_q) + 32'(process_noise_q);
    case (uword.op)
      OP_SUM:      add37 = 37'(accel_q) + 37'(bias_q);
      OP_ADD_BIAS: add37 = 37'(bias_q) + 37'(t_q);
      default:     add37 = 37'(speed_q) + 37'(t_q);
    endcase
  end

  // Datapath operations under control of the current word.
  always_comb begin
    speed_d  = speed_q;
    bias_d   = bias_q;
    unc_d    = unc_q;
    wcnt_d   = wcnt_q;
    seeded_d = seeded_q;
    corr_d   = corr_q;
    gps_d    = gps_q;
    accel_d  = accel_q;
    t_d      = t_q;
    prod_d   = prod_q;
    den_d    = den_q;
    rem_d    = rem_q;
    nlow_d   = nlow_q;
    quot_d   = quot_q;
    cnt_d    = cnt_q;
    k_d      = k_q;
    kb_d     = kb_q;
    ovalid_d = ovalid_q && !m_axis_tready;
    ospeed_d = ospeed_q;
    obias_d  = obias_q;
    ounc_d   = ounc_q;
    ocorr_d  = ocorr_q;

    if (in_acc) begin
      gps_d   = signed'(s_axis_tdata[31:0]);
      accel_d = signed'(s_axis_tdata[63:32]);
    end

    case (uword.op)
      OP_NOP: ;
      OP_SEED: begin
        if (!seeded_q) begin
          bias_d   = sat32(-37'(accel_q));
          seeded_d = 1'b1;
        end
        corr_d = (gps_q > 32'sd0) || (wcnt_q < warmup_items_q);
      end
      OP_SUM:       t_d = TMP_W'(sat32(add37));
      OP_MUL:       prod_d = PROD_W'(mul_a) * PROD_W'(mul_b);
      OP_RND:       t_d = signed'(rnd_sum[PROD_W-1:16]);
      OP_ADD_SPEED: speed_d = sat32(add37);
      OP_UNC_PN:    unc_d = unc_pn[31] ? '1 : unc_pn[UNC_W-1:0];
      OP_ABS:       t_d = speed_q[VAL_W-1] ? -TMP_W'(speed_q) : TMP_W'(speed_q);
      OP_RSEL:      den_d = DEN_W'(unc_q) + r_sel;
      OP_DIVINIT: begin
        rem_d  = DEN_W'(dividend[47:17]);
        nlow_d = dividend[16:0];
        quot_d = '0;
        cnt_d  = DIV_STEPS;
      end
      OP_DIVSTEP: begin
        rem_d  = trial_ge ? DEN_W'(trial - {1'b0, den_q}) : trial[DEN_W-1:0];
        nlow_d = {nlow_q[15:0], 1'b0};
        quot_d = {quot_q[GAIN_W-2:0], trial_ge};
        cnt_d  = cnt_q - 1'b1;
      end
      // A zero denominator means zero gain.
      OP_KSET:      k_d = (den_q == '0) ? '0 : quot_q;
      OP_DIFF:      t_d = TMP_W'(gps_q) - TMP_W'(speed_q);
      OP_KB:        kb_d = t_q[GAIN_W-1:0];
      OP_ADD_BIAS:  bias_d = sat32(add37);
      OP_UNC_SET: begin
        unc_d = (t_q > TMP_W'(32'sh7FFF_FFFF)) ? '1 : t_q[UNC_W-1:0];
      end
      OP_WARM: begin
        if (wcnt_q < warmup_items_q) begin
          wcnt_d = wcnt_q + 1'b1;
        end
      end
      OP_OUT: begin
        if (!out_stall) begin
          ovalid_d = 1'b1;
          ospeed_d = speed_q;
          obias_d  = bias_q;
          ounc_d   = unc_q;
          ocorr_d  = corr_q;
        end
      end
      default: ;
    endcase
  end

  // Control and filter state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q            <= ST_IDLE;
      step_time_q     <= RST_STEP_TIME;
      process_noise_q <= RST_PROCESS_NOISE;
      noise_floor_q   <= RST_NOISE_FLOOR;
      noise_slope_q   <= RST_NOISE_SLOPE;
      bias_gain_q     <= RST_BIAS_GAIN;
      warmup_items_q  <= RST_WARMUP_ITEMS;
      speed_q         <= '0;
      bias_q          <= '0;
      unc_q           <= '0;
      wcnt_q          <= 6'd1;
      seeded_q        <= 1'b0;
      corr_q          <= 1'b0;
      cnt_q           <= '0;
      ovalid_q        <= 1'b0;
    end else begin
      pc_q            <= pc_d;
      step_time_q     <= step_time_d;
      process_noise_q <= process_noise_d;
      noise_floor_q   <= noise_floor_d;
      noise_slope_q   <= noise_slope_d;
      bias_gain_q     <= bias_gain_d;
      warmup_items_q  <= warmup_items_d;
      speed_q         <= speed_d;
      bias_q          <= bias_d;
      unc_q           <= unc_d;
      wcnt_q          <= wcnt_d;
      seeded_q        <= seeded_d;
      corr_q          <= corr_d;
      cnt_q           <= cnt_d;
      ovalid_q        <= ovalid_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    gps_q    <= gps_d;
    accel_q  <= accel_d;
    t_q      <= t_d;
    prod_q   <= prod_d;
    den_q    <= den_d;
    rem_q    <= rem_d;
    nlow_q   <= nlow_d;
    quot_q   <= quot_d;
    k_q      <= k_d;
    kb_q     <= kb_d;
    ospeed_q <= ospeed_d;
    obias_q  <= obias_d;
    ounc_q   <= ounc_d;
    ocorr_q  <= ocorr_d;
  end

  // A request is never taken twice in a row; the program must run first.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("input taken again before the step program ran");

  // The divider remainder stays below the divisor.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (uword.op == OP_DIVSTEP && den_q != '0) |=> (rem_q < den_q))
    else $error("division remainder not below divisor");

  // The gain never exceeds one.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (uword.op == OP_KSET) |=> (k_q <= GAIN_ONE))
    else $error("Kalman gain above one");

endmodule

@@ test/scalar_kalman_speed_fusion_test.sv @@
// Self-checking testbench for the scalar Kalman speed fusion block.
// Predicts every result in Q16.16 integer arithmetic and compares it field by field.
// Depends on skf_pkg for register indexes and port widths, and on the block itself.
module scalar_kalman_speed_fusion_test;
  timeunit 1ns;
  timeprecision 1ps;

  import skf_pkg::*;

  localparam int unsigned CYCLE_LIMIT   = 1_000_000;
  localparam int unsigned SETTLE_CYCLES = 4;
  localparam int unsigned END_CYCLES    = 50;
  localparam int unsigned BUSY_PCT      = 26;
  localparam longint     Q16_HALF       = 32768;
  localparam longint     S32_TOP        = 64'sd2147483647;
  localparam longint     S32_BOTTOM     = -64'sd2147483648;

  // Indexes that select no register.
  localparam logic [CIDX_W-1:0] CFG_SPARE_A = 3'd6;
  localparam logic [CIDX_W-1:0] CFG_SPARE_B = 3'd7;

  // One result as it leaves the block.
  typedef struct packed {
    logic [VAL_W-1:0] speed;
    logic [VAL_W-1:0] bias;
    logic [UNC_W-1:0] unc;
    logic             corr;
  } fusion_result_t;

  logic              clk_i         = 1'b0;
  logic              rst_ni        = 1'b0;
  logic              s_axis_tvalid = 1'b0;
  logic              s_axis_tready;
  logic [63:0]       s_axis_tdata  = '0;  // ground_speed, forward_accel
  logic              m_axis_tvalid;
  logic              m_axis_tready = 1'b0;
  logic [95:0]       m_axis_tdata;        // fused_speed, accel_bias, uncertainty_out, pad
  logic              m_axis_tuser;        // corrected
  logic              cfg_we_i      = 1'b0;
  logic [CIDX_W-1:0] cfg_idx_i     = '0;
  logic [CFG_W-1:0]  cfg_wdata_i   = '0;

  // Register copies and filter state of the predictor.
  logic [16:0] dt_r       = RST_STEP_TIME;
  logic [20:0] pnoise_r   = RST_PROCESS_NOISE;
  logic [20:0] rfloor_r   = RST_NOISE_FLOOR;
  logic [16:0] rslope_r   = RST_NOISE_SLOPE;
  logic [16:0] bgain_r    = RST_BIAS_GAIN;
  logic [5:0]  warm_lim_r = RST_WARMUP_ITEMS;
  longint      speed_m    = 0;
  longint      bias_m     = 0;
  longint      unc_m      = 0;
  int unsigned warm_cnt_m = 1;
  bit          seeded_m   = 1'b0;

  fusion_result_t fusion_expect_q[$];
  int unsigned    idle_pct       = BUSY_PCT;
  int unsigned    hold_left      = 0;
  int unsigned    cycle_count    = 0;
  int unsigned    req_count      = 0;
  int unsigned    result_count   = 0;
  int unsigned    mismatch_count = 0;
  int unsigned    setting_count  = 0;

  scalar_kalman_speed_fusion DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  always #1 clk_i = ~clk_i;

  // Run limit in case the block hangs.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d results pending.", cycle_count,
               fusion_expect_q.size());
      $display("FAILED: results differ");
      $finish;
    end
  end

  function automatic longint clamp_s32(input longint v);
    if (v > S32_TOP) return S32_TOP;
    if (v < S32_BOTTOM) return S32_BOTTOM;
    return v;
  endfunction

  // Drop 16 fraction bits, rounding half away from zero.
  function automatic longint round_q16(input longint p);
    longint mag;
    longint r;
    mag = (p < 0) ? -p : p;
    r   = (mag + Q16_HALF) >> 16;
    return (p < 0) ? -r : r;
  endfunction

  // Advance the filter state by one request and return what the block should report.
  function automatic fusion_result_t fuse_step(input logic [31:0] gps_bits,
                                               input logic [31:0] acc_bits);
    fusion_result_t res;
    longint gps, acc, sum, dt, pn, fl, sl, bg, mag, rs, r, den, k, kb;
    logic corr;
    gps = $signed(gps_bits);
    acc = $signed(acc_bits);
    dt  = dt_r;
    pn  = pnoise_r;
    fl  = rfloor_r;
    sl  = rslope_r;
    bg  = bgain_r;

    // The first request after reset seeds the bias with the negated acceleration.
    if (!seeded_m) begin
      bias_m   = clamp_s32(-acc);
      seeded_m = 1'b1;
    end

    // Predict.
    sum     = clamp_s32(acc + bias_m);
    speed_m = clamp_s32(speed_m + round_q16(sum * dt));
    unc_m   = unc_m + pn;
    if (unc_m > S32_TOP) unc_m = S32_TOP;

    // Correct when the GPS speed is positive or warm-up is still running.
    corr = (gps > 0) || (warm_cnt_m < warm_lim_r);
    if (corr) begin
      mag = (speed_m < 0) ? -speed_m : speed_m;
      rs  = (sl * mag + Q16_HALF) >> 16;
      r   = (rs > fl) ? rs : fl;
      den = unc_m + r;
      k   = 0;
      if (den != 0) k = ((unc_m << 16) + den / 2) / den;
      speed_m = clamp_s32(speed_m + round_q16(k * (gps - speed_m)));
      kb      = (k * bg + Q16_HALF) >> 16;
      bias_m  = clamp_s32(bias_m + round_q16(kb * (gps - speed_m)));
      unc_m   = (unc_m * (65536 - k) + Q16_HALF) >> 16;
      if (unc_m > S32_TOP) unc_m = S32_TOP;
    end

    if (warm_cnt_m < warm_lim_r) warm_cnt_m = (warm_cnt_m + 1) & 6'h3F;

    res.speed = speed_m[31:0];
    res.bias  = bias_m[31:0];
    res.unc   = unc_m[30:0];
    res.corr  = corr;
    return res;
  endfunction

  // Offer one request, wait for it to be taken, then queue its prediction.
  task automatic send_item(input logic [31:0] gps, input logic [31:0] acc);
    while ($urandom_range(99) < idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {acc, gps};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    fusion_expect_q.push_back(fuse_step(gps, acc));
    req_count++;
  endtask

  // Stop offering and let every pending result come back.
  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    while (fusion_expect_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // One register write; the enable stays up until the caller lowers it.
  task automatic write_reg(input logic [CIDX_W-1:0] idx, input logic [CFG_W-1:0] value);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    case (idx)
      CFG_STEP_TIME:     dt_r       = value[16:0];
      CFG_PROCESS_NOISE: pnoise_r   = value[20:0];
      CFG_NOISE_FLOOR:   rfloor_r   = value[20:0];
      CFG_NOISE_SLOPE:   rslope_r   = value[16:0];
      CFG_BIAS_GAIN:     bgain_r    = value[16:0];
      CFG_WARMUP_ITEMS:  warm_lim_r = value[5:0];
      default: ;
    endcase
  endtask

  // Load a full register set once the block has gone quiet.
  task automatic apply_settings(input logic [CFG_W-1:0] dt, input logic [CFG_W-1:0] pn,
                                input logic [CFG_W-1:0] fl, input logic [CFG_W-1:0] sl,
                                input logic [CFG_W-1:0] bg, input logic [CFG_W-1:0] wu);
    wait_idle();
    write_reg(CFG_STEP_TIME, dt);
    write_reg(CFG_PROCESS_NOISE, pn);
    write_reg(CFG_NOISE_FLOOR, fl);
    write_reg(CFG_NOISE_SLOPE, sl);
    write_reg(CFG_BIAS_GAIN, bg);
    write_reg(CFG_WARMUP_ITEMS, wu);
    cfg_we_i <= 1'b0;
    setting_count++;
  endtask

  task automatic apply_defaults();
    apply_settings(CFG_W'(RST_STEP_TIME), CFG_W'(RST_PROCESS_NOISE),
                   CFG_W'(RST_NOISE_FLOOR), CFG_W'(RST_NOISE_SLOPE),
                   CFG_W'(RST_BIAS_GAIN), CFG_W'(RST_WARMUP_ITEMS));
  endtask

  // A register set drawn at random from a set range for each register.
  task automatic apply_random_settings();
    apply_settings(CFG_W'($urandom_range(1, 65536)), CFG_W'($urandom_range(0, 1048576)),
                   CFG_W'($urandom_range(1, 1048576)), CFG_W'($urandom_range(0, 65536)),
                   CFG_W'($urandom_range(0, 65536)), CFG_W'($urandom_range(0, 63)));
  endtask

  // Mostly plausible Q16.16 values within +/- span, with raw bits and edge values mixed in.
  function automatic logic [31:0] rand_q16(input int unsigned span);
    int unsigned sel;
    int          v;
    sel = $urandom_range(99);
    if (sel < 70) begin
      v = int'($urandom_range(0, span * 131072)) - int'(span * 65536);
      return v;
    end
    if (sel < 90) return $urandom;
    case ($urandom_range(4))
      0:       return 32'h0000_0000;
      1:       return 32'h0000_0001;
      2:       return 32'hFFFF_FFFF;
      3:       return 32'h7FFF_FFFF;
      default: return 32'h8000_0000;
    endcase
  endfunction

  task automatic report_field(input string name, input logic [31:0] want_v,
                              input logic [31:0] got_v);
    if (want_v !== got_v) begin
      mismatch_count++;
      $display("%0t: %s expected %h, got %h", $time, name, want_v, got_v);
    end
  endtask

  // Check each result against the oldest prediction and drive the receiver's ready.
  always @(posedge clk_i) begin : result_check
    fusion_result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      result_count++;
      if (fusion_expect_q.size() == 0) begin
        mismatch_count++;
        $display("%0t: result with no request pending, expected none, got %h", $time,
                 m_axis_tdata);
      end else begin
        want = fusion_expect_q.pop_front();
        report_field("fused_speed", want.speed, m_axis_tdata[31:0]);
        report_field("accel_bias", want.bias, m_axis_tdata[63:32]);
        report_field("uncertainty_out", {1'b0, want.unc}, {1'b0, m_axis_tdata[94:64]});
        report_field("corrected", {31'b0, want.corr}, {31'b0, m_axis_tuser});
      end
    end
    if (hold_left > 0) begin
      m_axis_tready <= 1'b0;
      hold_left--;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= idle_pct);
    end
  end

  // The very first request seeds the bias from the most negative acceleration.
  task automatic test_first_item_seed();
    send_item(32'h0005_0000, 32'h8000_0000);
  endtask

  // Extremes of both fields, including a zero GPS speed corrected only by warm-up.
  task automatic test_field_extremes();
    send_item(32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send_item(32'h8000_0000, 32'h8000_0000);
    send_item(32'h0000_0000, 32'h0000_0000);
    send_item(32'hFFFF_FFFF, 32'h0000_0001);
    send_item(32'h0000_0001, 32'hFFFF_FFFF);
    send_item(32'h0003_0000, 32'h0000_8000);
  endtask

  // With no noise at all the gain goes to one, then the denominator reaches zero.
  task automatic test_zero_noise();
    apply_settings(CFG_W'(RST_STEP_TIME), '0, '0, '0, CFG_W'(RST_BIAS_GAIN),
                   CFG_W'(RST_WARMUP_ITEMS));
    send_item(32'h0002_0000, 32'h0000_4000);
    send_item(32'h0004_0000, 32'hFFFF_C000);
    send_item(32'h0001_8000, 32'h0001_0000);
  endtask

  // A zero period disables prediction.
  task automatic test_zero_step_time();
    apply_settings('0, CFG_W'(RST_PROCESS_NOISE), CFG_W'(RST_NOISE_FLOOR),
                   CFG_W'(RST_NOISE_SLOPE), CFG_W'(RST_BIAS_GAIN),
                   CFG_W'(RST_WARMUP_ITEMS));
    send_item(32'h000A_0000, 32'h0003_0000);
    send_item(32'hFFF6_0000, 32'hFFFD_0000);
    send_item(32'h0000_0000, 32'h7FFF_FFFF);
  endtask

  // Values wider than the registers wrap; writes to spare indexes change nothing.
  task automatic test_wide_register_values();
    apply_settings('1, '1, '1, '1, '1, '1);
    @(posedge clk_i);
    write_reg(CFG_SPARE_A, CFG_W'($urandom));
    write_reg(CFG_SPARE_B, CFG_W'($urandom));
    cfg_we_i <= 1'b0;
    send_item(32'h0014_0000, 32'h0001_0000);
    send_item(32'hFFEC_0000, 32'hFFFF_0000);
    send_item(32'h0000_0000, 32'h0000_8000);
  endtask

  // A warm-up limit under the count stops forced correction and freezes the count.
  task automatic test_warmup_below_count();
    apply_settings(CFG_W'(RST_STEP_TIME), CFG_W'(RST_PROCESS_NOISE),
                   CFG_W'(RST_NOISE_FLOOR), CFG_W'(RST_NOISE_SLOPE),
                   CFG_W'(RST_BIAS_GAIN), '0);
    send_item(32'h0000_0000, 32'h0000_2000);
    send_item(32'hFFFE_0000, 32'hFFFF_E000);
    send_item(32'h0006_0000, 32'h0000_0000);
    send_item(32'h8000_0000, 32'h0001_0000);
  endtask

  // Random requests under defaults, minimum, maximum and random register sets.
  task automatic test_random_settings();
    for (int s = 0; s < 7; s++) begin
      case (s)
        0: apply_defaults();
        1: apply_settings(CFG_W'(1), '0, CFG_W'(1), '0, '0, '0);
        2: apply_settings(CFG_W'(65536), CFG_W'(1048576), CFG_W'(1048576),
                          CFG_W'(65536), CFG_W'(65536), CFG_W'(63));
        default: apply_random_settings();
      endcase
      repeat (150) send_item(rand_q16(60), rand_q16(20));
    end
  endtask

  // Neither side idles for a long stretch.
  task automatic test_no_idle_stretch();
    apply_defaults();
    idle_pct = 0;
    repeat (150) send_item(rand_q16(60), rand_q16(20));
    wait_idle();
    idle_pct = BUSY_PCT;
  endtask

  // The receiver holds off for a long time while requests keep coming.
  task automatic test_output_backpressure();
    apply_random_settings();
    hold_left = 500;
    repeat (40) send_item(rand_q16(60), rand_q16(20));
  endtask

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_first_item_seed();
    test_field_extremes();
    test_zero_noise();
    test_zero_step_time();
    test_wide_register_values();
    test_warmup_below_count();
    test_random_settings();
    test_no_idle_stretch();
    test_output_backpressure();

    wait_idle();
    repeat (END_CYCLES) @(posedge clk_i);

    $display("Sent %0d requests and checked %0d results under %0d register sets,",
             req_count, result_count, setting_count);
    $display("including zero noise, zero period, wrapped registers and a long stall.");
    if (mismatch_count == 0 && fusion_expect_q.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("%0d mismatches, %0d results missing.", mismatch_count,
               fusion_expect_q.size());
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

@@ scalar_kalman_speed_fusion.f @@
rtl/core/skf_pkg.sv
rtl/core/scalar_kalman_speed_fusion.sv
test/scalar_kalman_speed_fusion_test.sv
